[src/rcpl_pkg.sv]
`timescale 1ns / 1ps
// rcpl_pkg: shared constants for the rc pulse led controller
// register map, reset values, colour codes and throttle mapping constants
// no dependencies
package rcpl_pkg;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned REG_IDX_W  = 2;
    localparam int unsigned DIM_W      = 8;
    localparam int unsigned COLOUR_W   = 3;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [COLOUR_W-1:0]  colour_t;

    localparam reg_idx_t REG_SWITCH_ON_ABOVE = 2'd0;
    localparam reg_idx_t REG_RED_BELOW       = 2'd1;
    localparam reg_idx_t REG_BLUE_ABOVE      = 2'd2;
    localparam reg_idx_t REG_DIM_DEADBAND    = 2'd3;

    localparam logic [CFG_W-1:0] RST_SWITCH_ON_ABOVE = 16'd1500;
    localparam logic [CFG_W-1:0] RST_RED_BELOW       = 16'd1200;
    localparam logic [CFG_W-1:0] RST_BLUE_ABOVE      = 16'd1800;
    localparam logic [CFG_W-1:0] RST_DIM_DEADBAND    = 16'd10;

    localparam colour_t COLOUR_OFF   = 3'b000;
    localparam colour_t COLOUR_RED   = 3'b001;
    localparam colour_t COLOUR_GREEN = 3'b010;
    localparam colour_t COLOUR_BLUE  = 3'b100;

    // throttle mapping: dim = 255 - floor(d * 255 / 1000), d = w - 1000 in 1..999
    localparam int unsigned THR_LOW   = 1000;
    localparam int unsigned THR_HIGH  = 2000;
    localparam int unsigned THR_SPAN_W = 10;
    localparam int unsigned THR_RECIP_SHIFT = 18;
    localparam logic [16:0] THR_RECIP = 17'd66847;
    localparam logic [DIM_W-1:0] DIM_FULL = 8'd255;
    localparam logic [DIM_W-1:0] DIM_OFF  = 8'd0;

    localparam int unsigned THR_WIDTH_RESET = 1500;
    localparam int unsigned SW_WIDTH_RESET  = 1000;
    localparam int unsigned COL_WIDTH_RESET = 1000;

endpackage

[src/rcpl_pulse_if.sv]
`timescale 1ns / 1ps
// rcpl_pulse_if: input channel, one tick of three receiver pin levels
// valid/ready handshake, no dependencies
interface rcpl_pulse_if;
    logic valid;
    logic ready;
    logic throttle_level;
    logic switch_level;
    logic colour_level;

    modport source (output valid, input ready, output throttle_level, output switch_level,
                    output colour_level);
    modport sink (input valid, output ready, input throttle_level, input switch_level,
                  input colour_level);
endinterface

[src/rcpl_led_if.sv]
`timescale 1ns / 1ps
// rcpl_led_if: output channel, led drive state after one tick
// valid/ready handshake, no dependencies
interface rcpl_led_if;
    logic       valid;
    logic       ready;
    logic       enable_led;
    logic [7:0] dim_level;
    logic       red_on;
    logic       green_on;
    logic       blue_on;

    modport source (output valid, input ready, output enable_led, output dim_level,
                    output red_on, output green_on, output blue_on);
    modport sink (input valid, output ready, input enable_led, input dim_level,
                  input red_on, input green_on, input blue_on);
endinterface

[src/rcpl_chan_timer.sv]
`timescale 1ns / 1ps
// rcpl_chan_timer: high pulse timer for one receiver channel
// saturating counter, captured width and pending flag; no package use
module rcpl_chan_timer #(
    parameter int unsigned TIME_BITS   = 16,
    parameter int unsigned RESET_WIDTH = 1000
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 level,
    input  logic                 consume,
    output logic                 pending,
    output logic [TIME_BITS-1:0] width
);

    logic                 last_level_reg;
    logic                 last_level_next;
    logic                 measuring_reg;
    logic                 measuring_next;
    logic [TIME_BITS-1:0] count_reg;
    logic [TIME_BITS-1:0] count_next;
    logic [TIME_BITS-1:0] count_inc;
    logic [TIME_BITS-1:0] captured_reg;
    logic [TIME_BITS-1:0] captured_next;
    logic                 pending_reg;
    logic                 pending_next;
    logic                 capture;

    assign count_inc = (count_reg == {TIME_BITS{1'b1}}) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        measuring_next  = measuring_reg;
        count_next      = count_reg;
        capture         = 1'b0;
        last_level_next = level;
        if (level && !last_level_reg)
        begin
            measuring_next = 1'b1;
            count_next     = '0;
        end
        else if (measuring_reg)
        begin
            count_next = count_inc;
            if (!level && last_level_reg && !pending_reg)
            begin
                capture        = 1'b1;
                measuring_next = 1'b0;
            end
        end
    end

    assign pending       = pending_reg | capture;
    assign width         = capture ? count_inc : captured_reg;
    assign captured_next = width;
    assign pending_next  = pending & ~consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b1;
            measuring_reg  <= 1'b0;
            count_reg      <= '0;
            captured_reg   <= TIME_BITS'(RESET_WIDTH);
            pending_reg    <= 1'b0;
        end
        else if (step)
        begin
            last_level_reg <= last_level_next;
            measuring_reg  <= measuring_next;
            count_reg      <= count_next;
            captured_reg   <= captured_next;
            pending_reg    <= pending_next;
        end
    end

endmodule

[src/rc_pulse_led_controller_unit.sv]
`timescale 1ns / 1ps
// rc_pulse_led_controller_unit: rc receiver pulse decoder driving leds
// uses rcpl_pkg, rcpl_pulse_if, rcpl_led_if and rcpl_chan_timer
//
// channel   dir  protocol    payload
// pulse_in  in   valid/ready throttle_level, switch_level, colour_level
// led_out   out  valid/ready enable_led, dim_level[7:0], red_on, green_on, blue_on
// apb       in   apb write   4 x 16-bit registers at byte address 4*i
//
// one transfer per cycle sustained while led_out is ready; an input transfer reaches the result
// through the input register, then one pass of decode logic into the led state and result register
// the led state registers are the result register, so they hold while led_out stalls
// a stalled led_out backs up into the input register and then drops pulse_in.ready
// rst_n is asynchronous, active low; no clearing pass after reset
module rc_pulse_led_controller_unit #(
    parameter int unsigned TIME_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcpl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rcpl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rcpl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    rcpl_pulse_if.sink                      pulse_in,
    rcpl_led_if.source                      led_out
);

    localparam int unsigned CMP_W = (TIME_BITS > rcpl_pkg::CFG_W) ? TIME_BITS : rcpl_pkg::CFG_W;

    // configuration registers
    logic [rcpl_pkg::CFG_W-1:0] switch_on_above_reg;
    logic [rcpl_pkg::CFG_W-1:0] red_below_reg;
    logic [rcpl_pkg::CFG_W-1:0] blue_above_reg;
    logic [rcpl_pkg::CFG_W-1:0] dim_deadband_reg;
    logic                       cfg_write;
    rcpl_pkg::reg_idx_t         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_idx   = paddr[rcpl_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_on_above_reg <= rcpl_pkg::RST_SWITCH_ON_ABOVE;
            red_below_reg       <= rcpl_pkg::RST_RED_BELOW;
            blue_above_reg      <= rcpl_pkg::RST_BLUE_ABOVE;
            dim_deadband_reg    <= rcpl_pkg::RST_DIM_DEADBAND;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                rcpl_pkg::REG_SWITCH_ON_ABOVE: switch_on_above_reg <= pwdata[rcpl_pkg::CFG_W-1:0];
                rcpl_pkg::REG_RED_BELOW:       red_below_reg       <= pwdata[rcpl_pkg::CFG_W-1:0];
                rcpl_pkg::REG_BLUE_ABOVE:      blue_above_reg      <= pwdata[rcpl_pkg::CFG_W-1:0];
                rcpl_pkg::REG_DIM_DEADBAND:    dim_deadband_reg    <= pwdata[rcpl_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            rcpl_pkg::REG_SWITCH_ON_ABOVE: prdata = rcpl_pkg::APB_DATA_W'(switch_on_above_reg);
            rcpl_pkg::REG_RED_BELOW:       prdata = rcpl_pkg::APB_DATA_W'(red_below_reg);
            rcpl_pkg::REG_BLUE_ABOVE:      prdata = rcpl_pkg::APB_DATA_W'(blue_above_reg);
            rcpl_pkg::REG_DIM_DEADBAND:    prdata = rcpl_pkg::APB_DATA_W'(dim_deadband_reg);
            default:                       prdata = '0;
        endcase
    end

    // input register and result handshake
    logic s1_valid_reg;
    logic s1_thr_reg;
    logic s1_sw_reg;
    logic s1_col_reg;
    logic out_valid_reg;
    logic s2_free;
    logic step;
    logic in_xfer;

    assign s2_free         = ~out_valid_reg | led_out.ready;
    assign step            = s1_valid_reg & s2_free;
    assign pulse_in.ready  = ~s1_valid_reg | s2_free;
    assign in_xfer         = pulse_in.valid & pulse_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pulse_in.ready)
            begin
                s1_valid_reg <= pulse_in.valid;
            end
            if (s2_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_thr_reg <= pulse_in.throttle_level;
            s1_sw_reg  <= pulse_in.switch_level;
            s1_col_reg <= pulse_in.colour_level;
        end
    end

    // channel timers
    logic                 thr_pending;
    logic                 sw_pending;
    logic                 col_pending;
    logic [TIME_BITS-1:0] thr_width;
    logic [TIME_BITS-1:0] sw_width;
    logic [TIME_BITS-1:0] col_width;
    logic                 thr_consume;
    logic                 col_consume;

    rcpl_chan_timer #(
        .TIME_BITS   (TIME_BITS),
        .RESET_WIDTH (rcpl_pkg::THR_WIDTH_RESET)
    ) u_thr_timer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .level   (s1_thr_reg),
        .consume (thr_consume),
        .pending (thr_pending),
        .width   (thr_width)
    );

    rcpl_chan_timer #(
        .TIME_BITS   (TIME_BITS),
        .RESET_WIDTH (rcpl_pkg::SW_WIDTH_RESET)
    ) u_sw_timer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .level   (s1_sw_reg),
        .consume (sw_pending),
        .pending (sw_pending),
        .width   (sw_width)
    );

    rcpl_chan_timer #(
        .TIME_BITS   (TIME_BITS),
        .RESET_WIDTH (rcpl_pkg::COL_WIDTH_RESET)
    ) u_col_timer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .level   (s1_col_reg),
        .consume (col_consume),
        .pending (col_pending),
        .width   (col_width)
    );

    // led state, which is also the result register
    logic                       leds_enabled_reg;
    logic                       leds_enabled_next;
    logic                       sw_enable;
    logic [TIME_BITS-1:0]       applied_width_reg;
    logic [TIME_BITS-1:0]       applied_width_next;
    logic [rcpl_pkg::DIM_W-1:0] dim_reg;
    logic [rcpl_pkg::DIM_W-1:0] dim_next;
    rcpl_pkg::colour_t          colour_reg;
    rcpl_pkg::colour_t          colour_next;

    // throttle width to dim level
    logic [TIME_BITS-1:0]                  thr_delta;
    logic [TIME_BITS-1:0]                  thr_dist;
    logic [rcpl_pkg::THR_SPAN_W+16:0]      thr_prod;
    logic [rcpl_pkg::DIM_W-1:0]            thr_quot;
    logic [rcpl_pkg::DIM_W-1:0]            thr_dim;
    logic                                  thr_move;

    assign thr_delta = thr_width - TIME_BITS'(rcpl_pkg::THR_LOW);
    assign thr_prod  = thr_delta[rcpl_pkg::THR_SPAN_W-1:0] * rcpl_pkg::THR_RECIP;
    assign thr_quot  = thr_prod[rcpl_pkg::THR_RECIP_SHIFT +: rcpl_pkg::DIM_W];

    always_comb
    begin
        if (thr_width <= TIME_BITS'(rcpl_pkg::THR_LOW))
        begin
            thr_dim = rcpl_pkg::DIM_FULL;
        end
        else if (thr_width >= TIME_BITS'(rcpl_pkg::THR_HIGH))
        begin
            thr_dim = rcpl_pkg::DIM_OFF;
        end
        else
        begin
            thr_dim = rcpl_pkg::DIM_FULL - thr_quot;
        end
    end

    assign thr_dist = (thr_width > applied_width_reg) ? thr_width - applied_width_reg
                                                      : applied_width_reg - thr_width;
    assign thr_move = CMP_W'(thr_dist) > CMP_W'(dim_deadband_reg);

    assign sw_enable         = CMP_W'(sw_width) > CMP_W'(switch_on_above_reg);
    assign leds_enabled_next = sw_pending ? sw_enable : leds_enabled_reg;

    always_comb
    begin
        applied_width_next = applied_width_reg;
        dim_next           = dim_reg;
        colour_next        = colour_reg;
        if (sw_pending && !sw_enable)
        begin
            dim_next    = rcpl_pkg::DIM_OFF;
            colour_next = rcpl_pkg::COLOUR_OFF;
        end
        if (col_consume)
        begin
            if (CMP_W'(col_width) < CMP_W'(red_below_reg))
            begin
                colour_next = rcpl_pkg::COLOUR_RED;
            end
            else if (CMP_W'(col_width) > CMP_W'(blue_above_reg))
            begin
                colour_next = rcpl_pkg::COLOUR_BLUE;
            end
            else
            begin
                colour_next = rcpl_pkg::COLOUR_GREEN;
            end
        end
        if (thr_consume && thr_move)
        begin
            dim_next           = thr_dim;
            applied_width_next = thr_width;
        end
    end

    assign col_consume = leds_enabled_next & col_pending;
    assign thr_consume = leds_enabled_next & thr_pending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leds_enabled_reg  <= 1'b0;
            applied_width_reg <= TIME_BITS'(rcpl_pkg::THR_WIDTH_RESET);
            dim_reg           <= rcpl_pkg::DIM_OFF;
            colour_reg        <= rcpl_pkg::COLOUR_OFF;
        end
        else if (step)
        begin
            leds_enabled_reg  <= leds_enabled_next;
            applied_width_reg <= applied_width_next;
            dim_reg           <= dim_next;
            colour_reg        <= colour_next;
        end
    end

    assign led_out.valid      = out_valid_reg;
    assign led_out.enable_led = leds_enabled_reg;
    assign led_out.dim_level  = dim_reg;
    assign led_out.red_on     = colour_reg[0];
    assign led_out.green_on   = colour_reg[1];
    assign led_out.blue_on    = colour_reg[2];

`ifndef SYNTHESIS
    a_colour_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(colour_reg))
        else $error("more than one colour driven");

    a_dark_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        !leds_enabled_reg |-> (colour_reg == rcpl_pkg::COLOUR_OFF && dim_reg == rcpl_pkg::DIM_OFF))
        else $error("leds lit while disabled");

    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !led_out.ready |=> $stable(dim_reg) && $stable(colour_reg)
            && $stable(leds_enabled_reg))
        else $error("led state changed while result stalled");

    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed tick produced no result");

    a_input_kept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_free |=> s1_valid_reg)
        else $error("buffered tick lost while stalled");
`endif

endmodule

[tb/rc_pulse_led_controller_unit_tb.sv]
`timescale 1ns / 1ps
// rc_pulse_led_controller_unit_tb: self-checking bench for the rc pulse led controller
// sends pin-level ticks in bursts, predicts the led state after each tick, checks each transfer
// depends on rcpl_pkg, rcpl_pulse_if, rcpl_led_if and rc_pulse_led_controller_unit
module rc_pulse_led_controller_unit_tb;

    localparam int TICK_BITS = 16;
    localparam int DUTY_W = rcpl_pkg::DIM_W;
    localparam int CFG_BITS = rcpl_pkg::CFG_W;
    localparam int THR_CH = 0;
    localparam int SW_CH = 1;
    localparam int COL_CH = 2;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
    localparam logic [CFG_BITS-1:0] CFG_MAX = '1;

    typedef struct packed {
        logic              enable;
        logic [DUTY_W-1:0] duty;
        logic              red;
        logic              green;
        logic              blue;
    } led_state_t;

    typedef enum logic [1:0] {SINK_FREE, SINK_RANDOM, SINK_SPARSE, SINK_HEAVY} sink_mode_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [rcpl_pkg::APB_ADDR_W-1:0] paddr;
    logic [rcpl_pkg::APB_DATA_W-1:0] pwdata;
    logic [rcpl_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    rcpl_pulse_if pulse_ch();
    rcpl_led_if   led_ch();

    rc_pulse_led_controller_unit #(
        .TIME_BITS(TICK_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .pulse_in(pulse_ch),
        .led_out(led_ch)
    );

    // decoder state as predicted
    logic [2:0]           pin_prev;
    logic [2:0]           timing;
    logic [2:0]           fresh;
    logic [TICK_BITS-1:0] ticks [3];
    logic [TICK_BITS-1:0] width_cap [3];
    logic                 enabled;
    logic [TICK_BITS-1:0] last_applied;
    logic [DUTY_W-1:0]    duty;
    rcpl_pkg::colour_t    rgb;
    logic [CFG_BITS-1:0]  cfg_switch;
    logic [CFG_BITS-1:0]  cfg_red;
    logic [CFG_BITS-1:0]  cfg_blue;
    logic [CFG_BITS-1:0]  cfg_band;

    led_state_t  expected_leds[$];
    int          mismatches;
    logic        steady;
    int          burst_left;
    logic [2:0]  pins;
    int          run_left [3];
    logic [15:0] sink_cycle;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [DUTY_W-1:0] throttle_duty(input logic [TICK_BITS-1:0] w);
        int span;
        int level;
        if (w <= TICK_BITS'(rcpl_pkg::THR_LOW))
            return rcpl_pkg::DIM_FULL;
        if (w >= TICK_BITS'(rcpl_pkg::THR_HIGH))
            return rcpl_pkg::DIM_OFF;
        span = int'(w) - int'(rcpl_pkg::THR_LOW);
        level = int'(rcpl_pkg::DIM_FULL)
                - (span * int'(rcpl_pkg::DIM_FULL)) / int'(rcpl_pkg::THR_HIGH - rcpl_pkg::THR_LOW);
        return DUTY_W'(level);
    endfunction

    task automatic decoder_reset();
        pin_prev = 3'b111;
        timing = '0;
        fresh = '0;
        for (int ch = 0; ch < 3; ch++)
            ticks[ch] = '0;
        width_cap[THR_CH] = TICK_BITS'(rcpl_pkg::THR_WIDTH_RESET);
        width_cap[SW_CH] = TICK_BITS'(rcpl_pkg::SW_WIDTH_RESET);
        width_cap[COL_CH] = TICK_BITS'(rcpl_pkg::COL_WIDTH_RESET);
        enabled = 1'b0;
        last_applied = TICK_BITS'(rcpl_pkg::THR_WIDTH_RESET);
        duty = rcpl_pkg::DIM_OFF;
        rgb = rcpl_pkg::COLOUR_OFF;
        cfg_switch = rcpl_pkg::RST_SWITCH_ON_ABOVE;
        cfg_red = rcpl_pkg::RST_RED_BELOW;
        cfg_blue = rcpl_pkg::RST_BLUE_ABOVE;
        cfg_band = rcpl_pkg::RST_DIM_DEADBAND;
    endtask

    task automatic decode_tick(input logic [2:0] lv);
        int diff;
        led_state_t after_tick;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (lv[ch] && !pin_prev[ch])
            begin
                timing[ch] = 1'b1;
                ticks[ch] = '0;
            end
            else if (timing[ch])
            begin
                if (ticks[ch] != TICK_MAX)
                    ticks[ch] = ticks[ch] + 1'b1;
                if (!lv[ch] && pin_prev[ch] && !fresh[ch])
                begin
                    width_cap[ch] = ticks[ch];
                    fresh[ch] = 1'b1;
                    timing[ch] = 1'b0;
                end
            end
            pin_prev[ch] = lv[ch];
        end

        if (fresh[SW_CH])
        begin
            if (width_cap[SW_CH] > cfg_switch)
                enabled = 1'b1;
            else
            begin
                enabled = 1'b0;
                duty = rcpl_pkg::DIM_OFF;
                rgb = rcpl_pkg::COLOUR_OFF;
            end
            fresh[SW_CH] = 1'b0;
        end

        if (enabled && fresh[COL_CH])
        begin
            if (width_cap[COL_CH] < cfg_red)
                rgb = rcpl_pkg::COLOUR_RED;
            else if (width_cap[COL_CH] > cfg_blue)
                rgb = rcpl_pkg::COLOUR_BLUE;
            else
                rgb = rcpl_pkg::COLOUR_GREEN;
            fresh[COL_CH] = 1'b0;
        end

        if (enabled && fresh[THR_CH])
        begin
            diff = int'(width_cap[THR_CH]) - int'(last_applied);
            if (diff < 0)
                diff = -diff;
            if (diff > int'(cfg_band))
            begin
                duty = throttle_duty(width_cap[THR_CH]);
                last_applied = width_cap[THR_CH];
            end
            fresh[THR_CH] = 1'b0;
        end

        after_tick.enable = enabled;
        after_tick.duty = duty;
        after_tick.red = rgb[0];
        after_tick.green = rgb[1];
        after_tick.blue = rgb[2];
        expected_leds.push_back(after_tick);
    endtask

    task automatic check_transfer();
        led_state_t got;
        led_state_t want;
        got.enable = led_ch.enable_led;
        got.duty = led_ch.dim_level;
        got.red = led_ch.red_on;
        got.green = led_ch.green_on;
        got.blue = led_ch.blue_on;
        if (expected_leds.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected led transfer: en=%0d dim=%0d rgb=%b%b%b",
                         got.enable, got.duty, got.red, got.green, got.blue);
        end
        else
        begin
            want = expected_leds.pop_front();
            if (got.enable !== want.enable || got.duty !== want.duty || got.red !== want.red
                || got.green !== want.green || got.blue !== want.blue)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("led mismatch: exp en=%0d dim=%0d rgb=%b%b%b got en=%0d dim=%0d rgb=%b%b%b",
                             want.enable, want.duty, want.red, want.green, want.blue,
                             got.enable, got.duty, got.red, got.green, got.blue);
            end
        end
    endtask

    // led sink, stall pattern follows bits 9:8 of sink_cycle; always ready while steady
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_cycle <= '0;
            led_ch.ready <= 1'b0;
        end
        else
        begin
            if (led_ch.valid && led_ch.ready)
                check_transfer();
            sink_cycle <= sink_cycle + 1'b1;
            if (steady)
                led_ch.ready <= 1'b1;
            else
                case (sink_mode_t'(sink_cycle[9:8]))
                    SINK_FREE:   led_ch.ready <= 1'b1;
                    SINK_RANDOM: led_ch.ready <= ($urandom_range(0, 3) != 0);
                    SINK_SPARSE: led_ch.ready <= (sink_cycle[1:0] == 2'd0);
                    default:     led_ch.ready <= ($urandom_range(0, 9) < 4);
                endcase
        end
    end

    task automatic send_tick(input logic [2:0] lv);
        pulse_ch.valid <= 1'b1;
        pulse_ch.throttle_level <= lv[THR_CH];
        pulse_ch.switch_level <= lv[SW_CH];
        pulse_ch.colour_level <= lv[COL_CH];
        do
            @(posedge clk);
        while (!pulse_ch.ready);
        decode_tick(lv);
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                pulse_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(0, 15);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_pins(input int n);
        repeat (n) send_tick(pins);
    endtask

    task automatic pulse_on(input int ch, input int width);
        pins[ch] = 1'b1;
        send_pins(width);
        pins[ch] = 1'b0;
        send_pins(3);
    endtask

    // random pin activity on the channels selected by mask
    task automatic random_pins(input int n, input logic [2:0] mask);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 12)
                pins = (pins & ~mask) | (3'($urandom_range(0, 7)) & mask);
            else
                for (int ch = 0; ch < 3; ch++)
                begin
                    if (mask[ch])
                    begin
                        if (run_left[ch] == 0)
                        begin
                            pins[ch] = ~pins[ch];
                            run_left[ch] = $urandom_range(1, 14);
                        end
                        else
                            run_left[ch]--;
                    end
                end
            send_tick(pins);
        end
    endtask

    task automatic drain();
        pulse_ch.valid <= 1'b0;
        while (expected_leds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input rcpl_pkg::reg_idx_t idx, input logic [CFG_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= rcpl_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rcpl_pkg::REG_SWITCH_ON_ABOVE: cfg_switch = value;
            rcpl_pkg::REG_RED_BELOW:       cfg_red = value;
            rcpl_pkg::REG_BLUE_ABOVE:      cfg_blue = value;
            rcpl_pkg::REG_DIM_DEADBAND:    cfg_band = value;
            default: ;
        endcase
    endtask

    task automatic test_pin_edges();
        steady = 1'b1;
        pins = 3'b111;
        send_pins(4);
        // falling edges with no rising edge seen since reset
        pins = 3'b000;
        send_pins(4);
        // widths wait while disabled; the second colour fall is dropped
        pulse_on(COL_CH, 6);
        pulse_on(COL_CH, 4);
        pulse_on(THR_CH, 12);
        pulse_on(SW_CH, 30);
    endtask

    task automatic test_colour_select();
        steady = 1'b1;
        drain();
        apb_write(rcpl_pkg::REG_SWITCH_ON_ABOVE, 16'd20);
        apb_write(rcpl_pkg::REG_RED_BELOW, 16'd8);
        apb_write(rcpl_pkg::REG_BLUE_ABOVE, 16'd12);
        pulse_on(SW_CH, 21);
        pulse_on(COL_CH, 7);
        pulse_on(COL_CH, 8);
        pulse_on(COL_CH, 12);
        pulse_on(COL_CH, 13);
        pulse_on(SW_CH, 20);
        pulse_on(COL_CH, 9);
        pulse_on(SW_CH, 25);
    endtask

    task automatic test_throttle_map();
        steady = 1'b0;
        drain();
        apb_write(rcpl_pkg::REG_DIM_DEADBAND, 16'd3);
        pulse_on(THR_CH, 5);
        pulse_on(THR_CH, 8);
        pulse_on(THR_CH, 9);
        // long throttle pulse inside the mapped range, other channels busy meanwhile
        pins[THR_CH] = 1'b1;
        random_pins($urandom_range(1001, 1300), 3'b110);
        pins = 3'b000;
        send_pins(3);
        pulse_on(SW_CH, 25);
    endtask

    task automatic test_config_extremes();
        steady = 1'b0;
        drain();
        apb_write(rcpl_pkg::REG_SWITCH_ON_ABOVE, '0);
        apb_write(rcpl_pkg::REG_RED_BELOW, '0);
        apb_write(rcpl_pkg::REG_BLUE_ABOVE, CFG_MAX);
        apb_write(rcpl_pkg::REG_DIM_DEADBAND, CFG_MAX);
        pulse_on(SW_CH, 1);
        pulse_on(COL_CH, 1);
        pulse_on(THR_CH, 5);
        drain();
        apb_write(rcpl_pkg::REG_RED_BELOW, CFG_MAX);
        pulse_on(COL_CH, 3);
        drain();
        apb_write(rcpl_pkg::REG_RED_BELOW, '0);
        apb_write(rcpl_pkg::REG_BLUE_ABOVE, '0);
        apb_write(rcpl_pkg::REG_DIM_DEADBAND, '0);
        pulse_on(COL_CH, 2);
        pulse_on(THR_CH, 5);
        pulse_on(THR_CH, 5);
        pulse_on(THR_CH, 6);
    endtask

    task automatic test_random_pulses();
        steady = 1'b0;
        for (int phase = 0; phase < 2; phase++)
        begin
            drain();
            if (phase == 1)
            begin
                apb_write(rcpl_pkg::REG_SWITCH_ON_ABOVE, $urandom_range(0, 1) ? CFG_MAX : '0);
                apb_write(rcpl_pkg::REG_RED_BELOW, $urandom_range(0, 1) ? CFG_MAX : '0);
                apb_write(rcpl_pkg::REG_BLUE_ABOVE, $urandom_range(0, 1) ? CFG_MAX : '0);
                apb_write(rcpl_pkg::REG_DIM_DEADBAND, $urandom_range(0, 1) ? CFG_MAX : '0);
            end
            else
            begin
                apb_write(rcpl_pkg::REG_SWITCH_ON_ABOVE, CFG_BITS'($urandom_range(0, 12)));
                apb_write(rcpl_pkg::REG_RED_BELOW, CFG_BITS'($urandom_range(0, 8)));
                apb_write(rcpl_pkg::REG_BLUE_ABOVE, CFG_BITS'($urandom_range(4, 14)));
                apb_write(rcpl_pkg::REG_DIM_DEADBAND, CFG_BITS'($urandom_range(0, 6)));
            end
            random_pins(25, 3'b111);
            drain();
            random_pins(25, 3'b111);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pulse_ch.valid = 1'b0;
        pulse_ch.throttle_level = 1'b0;
        pulse_ch.switch_level = 1'b0;
        pulse_ch.colour_level = 1'b0;
        mismatches = 0;
        steady = 1'b1;
        burst_left = 0;
        pins = 3'b000;
        for (int ch = 0; ch < 3; ch++)
            run_left[ch] = 0;
        decoder_reset();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pin_edges();
        test_colour_select();
        test_throttle_map();
        test_config_extremes();
        test_random_pulses();

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_leds.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
